>>> sv/pmst_pkg.sv
`timescale 1ns / 1ps

package pmst_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int ADDR_W       = 2 * IDX_W;
    localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
    localparam int WEIGHT_W     = 16;
    localparam int CFG_W        = 5;
    localparam int FIELD_SPAN   = 16;
    localparam int FIELD_W      = 4;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(5);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic scan;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic v_small;
        logic scan_done;
        logic last_round;
        logic out_free;
    } dp_stat_t;

endpackage

>>> sv/pmst_if.sv
`timescale 1ns / 1ps

interface pmst_in_if;
    logic                         valid;
    logic                         ready;
    logic [pmst_pkg::FIELD_W-1:0] row;
    logic [pmst_pkg::FIELD_W-1:0] col;
    logic [pmst_pkg::WEIGHT_W-1:0] weight;
    logic                         last;

    modport source (output valid, output row, output col, output weight, output last,
                    input ready);
    modport sink (input valid, input row, input col, input weight, input last,
                  output ready);
endinterface

interface pmst_out_if;
    logic                          valid;
    logic                          ready;
    logic [pmst_pkg::FIELD_W-1:0]  from_vertex;
    logic [pmst_pkg::FIELD_W-1:0]  to_vertex;
    logic [pmst_pkg::WEIGHT_W-1:0] edge_weight;
    logic                          found;
    logic                          final_res;

    modport source (output valid, output from_vertex, output to_vertex, output edge_weight,
                    output found, output final_res, input ready);
    modport sink (input valid, input from_vertex, input to_vertex, input edge_weight,
                  input found, input final_res, output ready);
endinterface

>>> sv/pmst_ctrl.sv
`timescale 1ns / 1ps

module pmst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  pmst_pkg::dp_stat_t  stat,
    output pmst_pkg::ctl_cmd_t  cmd
);

    pmst_pkg::state_t state_reg;
    pmst_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmst_pkg::ST_IDLE:
            begin
                if (accept && in_last && !stat.v_small)
                begin
                    state_next = pmst_pkg::ST_SCAN;
                end
            end
            pmst_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = pmst_pkg::ST_EMIT;
                end
            end
            pmst_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_round ? pmst_pkg::ST_IDLE : pmst_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = pmst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.write = 1'b0;
        cmd.start = 1'b0;
        cmd.scan  = 1'b0;
        cmd.emit  = 1'b0;
        case (state_reg)
            pmst_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.write = in_valid;
                cmd.start = in_valid && in_last;
            end
            pmst_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            pmst_pkg::ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/pmst_datapath.sv
`timescale 1ns / 1ps

module pmst_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pmst_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [pmst_pkg::FIELD_W-1:0]   wr_row,
    input  logic [pmst_pkg::FIELD_W-1:0]   wr_col,
    input  logic [pmst_pkg::WEIGHT_W-1:0]  wr_weight,
    input  pmst_pkg::ctl_cmd_t             cmd,
    output pmst_pkg::dp_stat_t             stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [pmst_pkg::FIELD_W-1:0]   out_from,
    output logic [pmst_pkg::FIELD_W-1:0]   out_to,
    output logic [pmst_pkg::WEIGHT_W-1:0]  out_weight,
    output logic                           out_found,
    output logic                           out_final
);

    localparam int IW = pmst_pkg::IDX_W;
    localparam int WW = pmst_pkg::WEIGHT_W;
    localparam int CW = pmst_pkg::CFG_W;
    localparam int NV = pmst_pkg::MAX_VERTICES;
    localparam int FW = pmst_pkg::FIELD_W;

    logic [WW-1:0] mem [pmst_pkg::DEPTH];
    logic [pmst_pkg::DEPTH-1:0] mem_vld_reg;

    logic [CW-1:0] vcount_reg;
    logic [CW-1:0] eff_v;
    logic [CW-1:0] v_m1;
    logic [CW-1:0] v_m2;
    logic [IW-1:0] vmax;

    logic [NV-1:0] chosen_reg;
    logic [IW-1:0] round_reg;

    logic          issuing_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] j_reg;
    logic          p_valid_reg;
    logic [IW-1:0] p_i_reg;
    logic [IW-1:0] p_j_reg;
    logic [WW-1:0] rd_data_reg;
    logic          rd_vld_reg;
    logic [WW-1:0] rd_w;

    logic          have_reg;
    logic [WW-1:0] best_reg;
    logic [IW-1:0] bi_reg;
    logic [IW-1:0] bj_reg;
    logic [WW-1:0] w00_reg;

    logic          cand;
    logic          issue;
    logic [IW-1:0] to_sel;
    logic [pmst_pkg::ADDR_W-1:0] rd_addr;
    logic [pmst_pkg::ADDR_W-1:0] wr_addr;

    logic          out_valid_reg;
    logic [FW-1:0] out_from_reg;
    logic [FW-1:0] out_to_reg;
    logic [WW-1:0] out_weight_reg;
    logic          out_found_reg;
    logic          out_final_reg;

    // saturate the vertex count to the matrix size
    assign eff_v = (vcount_reg > CW'(NV)) ? CW'(NV) : vcount_reg;
    assign v_m1  = eff_v - CW'(1);
    assign v_m2  = eff_v - CW'(2);
    assign vmax  = v_m1[IW-1:0];

    assign rd_addr = {i_reg, j_reg};
    assign wr_addr = {wr_row[IW-1:0], wr_col[IW-1:0]};
    assign issue   = cmd.scan && issuing_reg;
    assign rd_w    = rd_vld_reg ? rd_data_reg : '0;
    assign cand    = p_valid_reg && chosen_reg[p_i_reg] && !chosen_reg[p_j_reg]
                     && (rd_w != '0) && (!have_reg || (rd_w < best_reg));
    assign to_sel  = have_reg ? bj_reg : '0;

    assign stat.v_small    = (eff_v < CW'(2));
    assign stat.scan_done  = !issuing_reg && !p_valid_reg;
    assign stat.last_round = (round_reg == v_m2[IW-1:0]);
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= pmst_pkg::VERTEX_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    // matrix storage, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_addr] <= wr_weight;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                mem_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= mem_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_reg  <= '0;
            round_reg   <= '0;
            issuing_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            p_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= issue;
            if (cmd.start || cmd.emit)
            begin
                issuing_reg <= 1'b1;
                i_reg       <= '0;
                j_reg       <= '0;
                have_reg    <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    if (j_reg == vmax)
                    begin
                        j_reg <= '0;
                        if (i_reg == vmax)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            i_reg <= i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                if (cand)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.start)
            begin
                // only vertex 0 starts selected
                chosen_reg    <= NV'(1);
                round_reg     <= '0;
            end
            else if (cmd.emit)
            begin
                chosen_reg[to_sel] <= 1'b1;
                round_reg          <= round_reg + IW'(1);
            end
        end
    end

    // scan pipeline payload and best candidate
    always_ff @(posedge clk)
    begin
        p_i_reg <= i_reg;
        p_j_reg <= j_reg;
        if (cand)
        begin
            best_reg <= rd_w;
            bi_reg   <= p_i_reg;
            bj_reg   <= p_j_reg;
        end
        if (p_valid_reg && (p_i_reg == '0) && (p_j_reg == '0))
        begin
            w00_reg <= rd_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_from_reg   <= FW'(have_reg ? bi_reg : '0);
            out_to_reg     <= FW'(to_sel);
            out_weight_reg <= have_reg ? best_reg : w00_reg;
            out_found_reg  <= have_reg;
            out_final_reg  <= stat.last_round;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_from   = out_from_reg;
    assign out_to     = out_to_reg;
    assign out_weight = out_weight_reg;
    assign out_found  = out_found_reg;
    assign out_final  = out_final_reg;

endmodule

>>> sv/prim_mst_adjacency_matrix_top.sv
`timescale 1ns / 1ps

// Prim minimum spanning tree over a 16 x 16 adjacency matrix of unsigned
// 16-bit weights (weight 0 means no edge). Each entry word writes one matrix
// cell; a word with last set writes its cell and then, if vertex_count is at
// least two, starts the walk from vertex 0 over the first vertex_count
// vertices (saturated to 16), producing vertex_count-1 result words, the
// final one flagged final_res. A round with no candidate edge yields from/to
// 0, the weight of cell [0][0] and found clear. Each round sweeps the matrix
// through its single read port, one cell per cycle; no entry word is taken
// while a walk runs. The matrix reads as all zeros after reset and is kept
// across walks. Write vertex_count (cfg_we/cfg_wdata) only while the block
// is idle.

module prim_mst_adjacency_matrix_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pmst_pkg::CFG_W-1:0]    cfg_wdata,
    pmst_in_if.sink                       entry,
    pmst_out_if.source                    result
);

    pmst_pkg::ctl_cmd_t cmd;
    pmst_pkg::dp_stat_t stat;
    logic               in_ready;

    // accept entry words only between walks
    assign entry.ready = in_ready;

    pmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (entry.valid),
        .in_last  (entry.last),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // matrix, selected-vertex set, scan pipeline and result register
    pmst_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .wr_row     (entry.row),
        .wr_col     (entry.col),
        .wr_weight  (entry.weight),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .out_from   (result.from_vertex),
        .out_to     (result.to_vertex),
        .out_weight (result.edge_weight),
        .out_found  (result.found),
        .out_final  (result.final_res)
    );

endmodule

>>> tb/sv/prim_mst_adjacency_matrix_top_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the Prim spanning-tree block.
// Entry words load the adjacency matrix; a word with last set starts a walk
// that returns vertex_count-1 edge words. A behavioral copy of the walk runs
// next to the block and queues the edges it expects; every edge word taken
// from the block is compared against the oldest queued edge.

module prim_mst_adjacency_matrix_top_test;
    import pmst_pkg::*;

    // One edge word as the predictor sees it.
    typedef struct packed {
        logic [FIELD_W-1:0]  from_v;
        logic [FIELD_W-1:0]  to_v;
        logic [WEIGHT_W-1:0] wt;
        logic                found;
        logic                tail;
    } tree_edge_t;

    // One entry word.
    typedef struct packed {
        logic [FIELD_W-1:0]  row;
        logic [FIELD_W-1:0]  col;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } entry_t;

    // Directed row: optional vertex_count write ahead of the word, the word
    // itself, and, where typed is set, the edge every round must return
    // (the final flag is filled in per round).
    typedef struct packed {
        logic                cfg_on;
        logic [CFG_W-1:0]    vc;
        logic [FIELD_W-1:0]  row;
        logic [FIELD_W-1:0]  col;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic                typed;
        logic [FIELD_W-1:0]  w_from;
        logic [FIELD_W-1:0]  w_to;
        logic [WEIGHT_W-1:0] w_wt;
        logic                w_found;
    } probe_t;

    localparam int N_PROBES    = 18;
    localparam int N_PHASES    = 14;
    localparam int PHASE_ITEMS = 28;
    // Longest receiver hold-off, in cycles.
    localparam int LONG_HOLD   = 1500;
    // Quiet time after the last edge word: covers the tail of a walk, or a
    // walk with no rounds at all, before a register write or the end.
    localparam int SETTLE      = 2 * (MAX_VERTICES * MAX_VERTICES + 3);
    localparam int TIMEOUT_NS  = 40_000_000;

    localparam probe_t PROBES [N_PROBES] = '{
        // after reset: empty matrix, V=5, four rounds with no candidate
        '{1'b0, 5'd0,  4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 4'd0, 4'd0, 16'h0000, 1'b0},
        // two vertices, heaviest weight on the only edge
        '{1'b1, 5'd2,  4'd0,  4'd1,  16'hFFFF, 1'b1, 1'b1, 4'd0, 4'd1, 16'hFFFF, 1'b1},
        // lightest nonzero weight
        '{1'b0, 5'd0,  4'd0,  4'd1,  16'h0001, 1'b1, 1'b1, 4'd0, 4'd1, 16'h0001, 1'b1},
        // edge erased by weight zero: no candidate
        '{1'b0, 5'd0,  4'd0,  4'd1,  16'h0000, 1'b1, 1'b1, 4'd0, 4'd0, 16'h0000, 1'b0},
        // vertex count zero and one: walk has no rounds
        '{1'b1, 5'd0,  4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b1, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b1, 5'd1,  4'd15, 4'd0,  16'hAAAA, 1'b1, 1'b1, 4'd0, 4'd0, 16'h0000, 1'b0},
        // full-size graph: plain writes, then a walk
        '{1'b1, 5'd16, 4'd0,  4'd15, 16'h5555, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd15, 4'd14, 16'h0003, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd14, 4'd13, 16'h0002, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd0,  4'd7,  16'h5555, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd7,  4'd14, 16'h0001, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        // nonzero [0][0] shows up in the rounds with no candidate
        '{1'b0, 5'd0,  4'd0,  4'd0,  16'h0007, 1'b1, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        // vertex count above the matrix size saturates
        '{1'b1, 5'd31, 4'd5,  4'd5,  16'h0000, 1'b1, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        // equal weights: the first one in scan order wins
        '{1'b1, 5'd3,  4'd0,  4'd1,  16'h0009, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd0,  4'd2,  16'h0009, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd1,  4'd2,  16'h0004, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd2,  4'd1,  16'h0004, 1'b1, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0},
        '{1'b0, 5'd0,  4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0000, 1'b0}
    };

    // Mostly small graphs; a few full-size and saturated ones.
    localparam logic [CFG_W-1:0] PHASE_VC [N_PHASES] = '{
        5'd4, 5'd16, 5'd2, 5'd6, 5'd0, 5'd31, 5'd3,
        5'd9, 5'd1, 5'd5, 5'd12, 5'd2, 5'd17, 5'd7
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;

    pmst_in_if  entry_ch ();
    pmst_out_if edge_ch ();

    prim_mst_adjacency_matrix_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .entry     (entry_ch),
        .result    (edge_ch)
    );

    // Predictor state: the matrix copy and the vertex_count copy.
    logic [WEIGHT_W-1:0] adj [MAX_VERTICES][MAX_VERTICES];
    logic [CFG_W-1:0]    tree_vc;
    tree_edge_t          exp_edges [$];

    int  mismatches  = 0;
    bit  src_idle_on = 1'b1;
    bit  snk_idle_on = 1'b1;
    int  hold_ticket = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH t=%0t %s", $time, msg);
        mismatches++;
    endtask

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap(input bit on);
        int p;
        if (!on)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Weight mix: full range, small values to force ties, erasures, extremes.
    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int p;
        p = $urandom_range(0, 9);
        if (p < 5)
            return WEIGHT_W'($urandom);
        if (p < 8)
            return WEIGHT_W'($urandom_range(1, 4));
        if (p == 8)
            return '0;
        return $urandom_range(0, 1) ? {WEIGHT_W{1'b1}} : WEIGHT_W'(1);
    endfunction

    // Apply one accepted entry word to the matrix copy and, on last, run the
    // walk: each round scans selected rows, then columns, in ascending order
    // and keeps the first strictly smaller nonzero weight into an unselected
    // column. With no candidate the round yields 0->0 carrying [0][0].
    task automatic take_entry(input entry_t e, input logic typed, input tree_edge_t want);
        int                  v;
        int                  rounds;
        int                  br;
        int                  bc;
        bit                  have;
        logic [WEIGHT_W-1:0] best;
        bit                  picked [MAX_VERTICES];
        tree_edge_t          nxt;
        adj[e.row][e.col] = e.weight;
        if (!e.last)
            return;
        v = (tree_vc > MAX_VERTICES) ? MAX_VERTICES : int'(tree_vc);
        if (v < 2)
            return;
        rounds = v - 1;
        foreach (picked[i])
            picked[i] = 1'b0;
        picked[0] = 1'b1;
        for (int k = 0; k < rounds; k++)
        begin
            have = 1'b0;
            best = '0;
            br   = 0;
            bc   = 0;
            for (int i = 0; i < v; i++)
            begin
                if (!picked[i])
                    continue;
                for (int j = 0; j < v; j++)
                begin
                    if (picked[j] || adj[i][j] == '0)
                        continue;
                    if (!have || adj[i][j] < best)
                    begin
                        have = 1'b1;
                        best = adj[i][j];
                        br   = i;
                        bc   = j;
                    end
                end
            end
            nxt.from_v = FIELD_W'(br);
            nxt.to_v   = FIELD_W'(bc);
            nxt.wt     = adj[br][bc];
            nxt.found  = have;
            picked[bc] = 1'b1;
            // Rows with a typed answer use it instead of the computed edge.
            if (typed)
                nxt = want;
            nxt.tail = (k == rounds - 1);
            exp_edges.push_back(nxt);
        end
    endtask

    // Offer one entry word after an optional gap; hold it until taken.
    task automatic put_entry(input entry_t e, input int gap, input logic typed,
                             input tree_edge_t want);
        if (gap > 0)
        begin
            @(negedge clk);
            entry_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        entry_ch.valid  <= 1'b1;
        entry_ch.row    <= e.row;
        entry_ch.col    <= e.col;
        entry_ch.weight <= e.weight;
        entry_ch.last   <= e.last;
        @(posedge clk);
        while (!entry_ch.ready)
            @(posedge clk);
        take_entry(e, typed, want);
    endtask

    task automatic park_sender();
        @(negedge clk);
        entry_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (exp_edges.size() != 0)
            @(posedge clk);
    endtask

    // Write vertex_count with the block idle: drain, let any walk without
    // rounds finish, then pulse the write enable for one cycle.
    task automatic set_vertex_count(input logic [CFG_W-1:0] v);
        park_sender();
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tree_vc = v;
    endtask

    // Result side: random back-pressure, plus a long hold-off whenever the
    // stimulus asks for one.
    initial
    begin : edge_sink
        int hold_served;
        int n;
        hold_served   = 0;
        edge_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_ticket != hold_served)
            begin
                edge_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_served++;
            end
            else
            begin
                n = pick_gap(snk_idle_on);
                if (n == 0)
                    edge_ch.ready <= 1'b1;
                else
                begin
                    edge_ch.ready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // Compare every edge word taken from the block with the oldest expectation.
    always @(posedge clk)
    begin : check_edges
        tree_edge_t want;
        if (rst_n && edge_ch.valid && edge_ch.ready)
        begin
            if (exp_edges.size() == 0)
                note_mismatch($sformatf("unexpected edge word %0d->%0d w=%0d",
                                        edge_ch.from_vertex, edge_ch.to_vertex,
                                        edge_ch.edge_weight));
            else
            begin
                want = exp_edges.pop_front();
                if (edge_ch.from_vertex !== want.from_v)
                    note_mismatch($sformatf("from_vertex got %0d want %0d",
                                            edge_ch.from_vertex, want.from_v));
                if (edge_ch.to_vertex !== want.to_v)
                    note_mismatch($sformatf("to_vertex got %0d want %0d",
                                            edge_ch.to_vertex, want.to_v));
                if (edge_ch.edge_weight !== want.wt)
                    note_mismatch($sformatf("edge_weight got %0d want %0d",
                                            edge_ch.edge_weight, want.wt));
                if (edge_ch.found !== want.found)
                    note_mismatch($sformatf("found got %0b want %0b",
                                            edge_ch.found, want.found));
                if (edge_ch.final_res !== want.tail)
                    note_mismatch($sformatf("final_res got %0b want %0b",
                                            edge_ch.final_res, want.tail));
            end
        end
    end

    initial
    begin : stimulus
        entry_t     e;
        entry_t     mirror;
        tree_edge_t want;
        int         span;
        int         sent;
        int         n;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        entry_ch.valid  = 1'b0;
        entry_ch.row    = '0;
        entry_ch.col    = '0;
        entry_ch.weight = '0;
        entry_ch.last   = 1'b0;
        foreach (adj[i, j])
            adj[i][j] = '0;
        tree_vc = VERTEX_COUNT_RESET;

        // Hold reset, then release it away from the rising edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows.
        for (int p = 0; p < N_PROBES; p++)
        begin
            if (PROBES[p].cfg_on)
                set_vertex_count(PROBES[p].vc);
            e.row       = PROBES[p].row;
            e.col       = PROBES[p].col;
            e.weight    = PROBES[p].weight;
            e.last      = PROBES[p].last;
            want.from_v = PROBES[p].w_from;
            want.to_v   = PROBES[p].w_to;
            want.wt     = PROBES[p].w_wt;
            want.found  = PROBES[p].w_found;
            want.tail   = 1'b0;
            put_entry(e, pick_gap(src_idle_on), PROBES[p].typed, want);
        end

        // Random phases, one vertex_count each.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_vertex_count(PHASE_VC[ph]);
            src_idle_on = (ph % 3 != 1);
            snk_idle_on = (ph % 4 != 2);
            // Stall the result side for a long stretch while loads keep coming.
            if (ph == 1 || ph == 10)
                hold_ticket++;
            span = (PHASE_VC[ph] > MAX_VERTICES) ? MAX_VERTICES : int'(PHASE_VC[ph]);
            if (span < 2)
                span = 4;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 82)
                begin
                    // Well-formed load: entries inside the walked vertices,
                    // some mirrored, closed by a word with last set.
                    n = $urandom_range(1, span + 2);
                    for (int k = 0; k <= n; k++)
                    begin
                        e.row    = FIELD_W'($urandom_range(0, span - 1));
                        e.col    = FIELD_W'($urandom_range(0, span - 1));
                        e.weight = pick_weight();
                        e.last   = (k == n);
                        put_entry(e, pick_gap(src_idle_on), 1'b0, '0);
                        sent++;
                        if (!e.last && $urandom_range(0, 2) == 0)
                        begin
                            mirror     = e;
                            mirror.row = e.col;
                            mirror.col = e.row;
                            put_entry(mirror, pick_gap(src_idle_on), 1'b0, '0);
                            sent++;
                        end
                    end
                end
                else
                begin
                    // Noise: anywhere in the matrix, last now and then.
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                    begin
                        e.row    = FIELD_W'($urandom_range(0, MAX_VERTICES - 1));
                        e.col    = FIELD_W'($urandom_range(0, MAX_VERTICES - 1));
                        e.weight = WEIGHT_W'($urandom);
                        e.last   = ($urandom_range(0, 7) == 0);
                        put_entry(e, pick_gap(src_idle_on), 1'b0, '0);
                        sent++;
                    end
                end
                // Pause the sender now and then until all edges are back.
                if ($urandom_range(0, 15) == 0)
                begin
                    park_sender();
                    wait_drained();
                end
            end
        end

        park_sender();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
sv/pmst_pkg.sv
sv/pmst_if.sv
sv/pmst_ctrl.sv
sv/pmst_datapath.sv
sv/prim_mst_adjacency_matrix_top.sv
tb/sv/prim_mst_adjacency_matrix_top_test.sv
